[rtl/core/tlpeq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpeq_pkg: shared types and constants of the priority event queue
// Entry layout, kind tables, sort key and sequencer states.
// ----------------------------------------------------------------------------
package tlpeq_pkg;

    // queue size and derived widths
    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int KIND_W  = 4;
    localparam int PRIO_W  = 2;
    localparam int GROUP_W = 2;
    localparam int STAMP_W = 5;
    localparam int KEY_W   = PRIO_W + 1;

    // number of defined event kinds
    localparam logic [KIND_W-1:0] NUM_KINDS = 4'd9;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // one queue entry as kept in memory
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PRIO_W-1:0]  prio;
        logic [GROUP_W-1:0] group;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DRAIN
    } t_state;

    // kind to priority table
    function automatic logic [PRIO_W-1:0] kind_priority(input logic [KIND_W-1:0] kind);
        logic [PRIO_W-1:0] p;
        case (kind)
            4'd0: p = 2'd0;
            4'd1: p = 2'd1;
            4'd2: p = 2'd2;
            4'd3: p = 2'd0;
            4'd4: p = 2'd0;
            4'd5: p = 2'd1;
            4'd6: p = 2'd1;
            4'd7: p = 2'd2;
            4'd8: p = 2'd2;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // kind to group table
    function automatic logic [GROUP_W-1:0] kind_group(input logic [KIND_W-1:0] kind);
        logic [GROUP_W-1:0] g;
        case (kind)
            4'd0: g = 2'd0;
            4'd1: g = 2'd0;
            4'd2: g = 2'd0;
            4'd3: g = 2'd1;
            4'd4: g = 2'd2;
            4'd5: g = 2'd1;
            4'd6: g = 2'd2;
            4'd7: g = 2'd1;
            4'd8: g = 2'd2;
            default: g = 2'd0;
        endcase
        return g;
    endfunction

    // sort key: group a ahead of b and c, then lower priority first
    function automatic logic [KEY_W-1:0] sort_key(input logic [GROUP_W-1:0] group,
                                                  input logic [PRIO_W-1:0] prio);
        return {(group != '0), prio};
    endfunction

endpackage

[rtl/core/tlpeq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpeq_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlpeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/two_level_priority_event_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_priority_event_queue_unit: sorted insertion event queue
// Inserts events in key order by walking the queue memory one entry per
// cycle; a drain streams the whole queue out in order and empties it.
// ----------------------------------------------------------------------------
//  channel   | handshake            | word
//  ----------+----------------------+--------------------------------------
//  command   | start, busy          | i_cmd, i_event_kind
//  result    | o_valid (strobe)     | o_out_kind, o_out_priority,
//            |                      | o_out_group, o_out_order, o_last_flag
//
//  A valid insert keeps busy high while it moves past s entries (s from 0
//  to QUEUE_DEPTH-1) and writes the new entry: one key compare and one
//  memory move per cycle. Inserts of unknown kinds or into a full queue
//  never raise busy. A drain keeps busy high while it puts out each entry
//  as one result word per cycle on o_valid; an empty drain never raises busy.
//  Synchronous active-low reset empties the queue; no clearing pass.
//  The receiver cannot stall: each result word is shown for one cycle.
// ----------------------------------------------------------------------------
module two_level_priority_event_queue_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [tlpeq_pkg::KIND_W-1:0]    i_event_kind,
    output logic                            o_valid,
    output logic [tlpeq_pkg::KIND_W-1:0]    o_out_kind,
    output logic [tlpeq_pkg::PRIO_W-1:0]    o_out_priority,
    output logic [tlpeq_pkg::GROUP_W-1:0]   o_out_group,
    output logic [tlpeq_pkg::STAMP_W-1:0]   o_out_order,
    output logic                            o_last_flag
);

    localparam int CNT_W = tlpeq_pkg::CNT_W;
    localparam int IDX_W = tlpeq_pkg::IDX_W;

    tlpeq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    tlpeq_pkg::t_entry r_new, n_new;

    // memory controls
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    tlpeq_pkg::t_entry ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    tlpeq_pkg::t_entry ram_rdata;

    // decoded conditions
    logic              w_accept;
    logic              w_ins_ok;
    logic              w_drain_ok;
    logic              w_shift;
    logic              w_last;
    logic [CNT_W-1:0]  w_pos_m1;
    logic [CNT_W-1:0]  w_pos_m2;
    logic [CNT_W-1:0]  w_pos_p1;
    logic [CNT_W-1:0]  w_cnt_m1;
    tlpeq_pkg::t_entry w_in_entry;

    // queue memory
    tlpeq_ram #(
        .WIDTH (tlpeq_pkg::ENTRY_W),
        .DEPTH (tlpeq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command decode
    assign busy       = (r_state != tlpeq_pkg::ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_ins_ok   = (i_cmd == tlpeq_pkg::CMD_INSERT)
                        && (i_event_kind < tlpeq_pkg::NUM_KINDS)
                        && (r_count < CNT_W'(tlpeq_pkg::QUEUE_DEPTH));
    assign w_drain_ok = (i_cmd == tlpeq_pkg::CMD_DRAIN) && (r_count != '0);

    // position arithmetic
    assign w_pos_m1 = r_pos - CNT_W'(1);
    assign w_pos_m2 = r_pos - CNT_W'(2);
    assign w_pos_p1 = r_pos + CNT_W'(1);
    assign w_cnt_m1 = r_count - CNT_W'(1);

    // entry built from the incoming word
    assign w_in_entry.kind  = i_event_kind;
    assign w_in_entry.prio  = tlpeq_pkg::kind_priority(i_event_kind);
    assign w_in_entry.group = tlpeq_pkg::kind_group(i_event_kind);
    assign w_in_entry.stamp = r_count[tlpeq_pkg::STAMP_W-1:0];

    // shared key compare: move the entry ahead of the new one back by one
    assign w_shift = (r_pos != '0)
                     && (tlpeq_pkg::sort_key(r_new.group, r_new.prio)
                         < tlpeq_pkg::sort_key(ram_rdata.group, ram_rdata.prio));

    // final word of a drain
    assign w_last = (r_pos == w_cnt_m1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpeq_pkg::ST_IDLE: begin
                if (w_accept && w_ins_ok) begin
                    n_state = tlpeq_pkg::ST_INSERT;
                end else if (w_accept && w_drain_ok) begin
                    n_state = tlpeq_pkg::ST_DRAIN;
                end
            end
            tlpeq_pkg::ST_INSERT: begin
                if (!w_shift) begin
                    n_state = tlpeq_pkg::ST_IDLE;
                end
            end
            tlpeq_pkg::ST_DRAIN: begin
                if (w_last) begin
                    n_state = tlpeq_pkg::ST_IDLE;
                end
            end
            default: n_state = tlpeq_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_pos[IDX_W-1:0];
        ram_wdata   = r_new;
        ram_raddr   = w_pos_m2[IDX_W-1:0];
        n_pos       = r_pos;
        n_count     = r_count;
        n_new       = r_new;
        o_valid     = 1'b0;
        o_last_flag = 1'b0;
        case (r_state)
            tlpeq_pkg::ST_IDLE: begin
                // fetch the tail entry for the first compare
                ram_raddr = w_cnt_m1[IDX_W-1:0];
                if (w_accept && w_ins_ok) begin
                    n_new = w_in_entry;
                    n_pos = r_count;
                end else if (w_accept && w_drain_ok) begin
                    ram_raddr = '0;
                    n_pos     = '0;
                end
            end
            tlpeq_pkg::ST_INSERT: begin
                ram_we = 1'b1;
                if (w_shift) begin
                    ram_wdata = ram_rdata;
                    ram_raddr = w_pos_m2[IDX_W-1:0];
                    n_pos     = w_pos_m1;
                end else begin
                    ram_wdata = r_new;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            tlpeq_pkg::ST_DRAIN: begin
                o_valid     = 1'b1;
                o_last_flag = w_last;
                ram_raddr   = w_pos_p1[IDX_W-1:0];
                n_pos       = w_pos_p1;
                if (w_last) begin
                    n_count = '0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // result word straight from the memory read register
    assign o_out_kind     = ram_rdata.kind;
    assign o_out_priority = ram_rdata.prio;
    assign o_out_group    = ram_rdata.group;
    assign o_out_order    = ram_rdata.stamp;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpeq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_new <= n_new;
    end

endmodule

[rtl/core/tlpeq_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpeq_chk: port-level checks of the event queue
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module tlpeq_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cmd,
    input logic o_valid,
    input logic o_last_flag
);

    // result words only appear while a command is in progress
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word while idle");

    // an insert never produces a result word
    a_insert_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == tlpeq_pkg::CMD_INSERT) |=> !o_valid)
        else $error("result word after insert");

    // drain words come back to back until the last one
    a_drain_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_flag) |=> o_valid)
        else $error("gap inside drain run");

    // the block is free again right after the last word
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_flag) |=> !busy)
        else $error("busy after last word");

endmodule

bind two_level_priority_event_queue_unit tlpeq_chk u_tlpeq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .o_last_flag (o_last_flag)
);
